/* rtl/core/lfpd_pkg.sv */
// Shared types, constants and functions for the line-follow PD drive block.
package lfpd_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_GAIN_ERROR      = 3'd0;
  localparam logic [2:0] REG_GAIN_RATE_FAST  = 3'd1;
  localparam logic [2:0] REG_GAIN_RATE_SLOW  = 3'd2;
  localparam logic [2:0] REG_SPEED_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_DRIVE_LIMIT     = 3'd4;

  localparam logic [7:0] RST_GAIN_ERROR      = 8'd20;
  localparam logic [7:0] RST_GAIN_RATE_FAST  = 8'd150;
  localparam logic [7:0] RST_GAIN_RATE_SLOW  = 8'd120;
  localparam logic [8:0] RST_SPEED_THRESHOLD = 9'd300;
  localparam logic [8:0] RST_DRIVE_LIMIT     = 9'd400;

  typedef logic [7:0]        code_t;
  typedef logic [7:0]        sense_t;
  typedef logic [8:0]        speed_t;
  typedef logic signed [9:0] drive_t;
  typedef logic signed [3:0] perr_t;

  typedef struct packed {
    logic [7:0] gain_error;
    logic [7:0] gain_rate_fast;
    logic [7:0] gain_rate_slow;
    logic [8:0] speed_threshold;
    logic [8:0] drive_limit;
  } cfg_t;

  typedef struct packed {
    logic  hit;
    perr_t err;
  } dec_t;

  function automatic dec_t decode_pattern(input sense_t bits);
    dec_t d;
    d.hit = 1'b1;
    d.err = 4'sd0;
    case (bits)
      8'h7F: d.err = -4'sd7;
      8'h3F: d.err = -4'sd6;
      8'hBF: d.err = -4'sd5;
      8'h9F: d.err = -4'sd4;
      8'hDF: d.err = -4'sd3;
      8'hCF: d.err = -4'sd2;
      8'hEF: d.err = -4'sd1;
      8'hE7: d.err = 4'sd0;
      8'hF7: d.err = 4'sd1;
      8'hF3: d.err = 4'sd2;
      8'hFB: d.err = 4'sd3;
      8'hF9: d.err = 4'sd4;
      8'hFD: d.err = 4'sd5;
      8'hFC: d.err = 4'sd6;
      8'hFE: d.err = 4'sd7;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic drive_t clamp_drive(input logic signed [15:0] v,
                                         input logic [8:0] lim);
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    hi = $signed({7'd0, lim});
    lo = -hi;
    if (v > hi) begin
      return drive_t'(hi);
    end else if (v < lo) begin
      return drive_t'(lo);
    end
    return drive_t'(v);
  endfunction

endpackage

/* rtl/core/lfpd_ifs.sv */
// Valid/ready channel interfaces for sensor requests and drive results.
interface lfpd_in_if;
  logic              valid;
  logic              ready;
  lfpd_pkg::code_t   echo_code;
  lfpd_pkg::sense_t  sensor_bits;
  lfpd_pkg::code_t   line_color;
  lfpd_pkg::speed_t  top_speed;

  modport source (output valid, output echo_code, output sensor_bits,
                  output line_color, output top_speed, input ready);
  modport sink (input valid, input echo_code, input sensor_bits,
                input line_color, input top_speed, output ready);
endinterface

interface lfpd_out_if;
  logic              valid;
  logic              ready;
  lfpd_pkg::drive_t  left_drive;
  lfpd_pkg::drive_t  right_drive;
  lfpd_pkg::perr_t   position_error;

  modport source (output valid, output left_drive, output right_drive,
                  output position_error, input ready);
  modport sink (input valid, input left_drive, input right_drive,
                input position_error, output ready);
endinterface

/* rtl/core/line_follow_pd_drive_top.sv */
// Top level of the PD line follower with differential drive outputs.
// The block takes one sensor request per clock cycle while the output is not
// stalled. A request is captured in an input register, and the pattern
// decode, the two gain multiplies, the sums and the clamps all happen in the
// single stage in front of the result register, which holds the drive result
// and feeds the drive outputs. A request whose echoed color code differs
// from the requested line color yields no result and
// leaves the stored previous error untouched. A request leaves the input
// register only when the result register is free or emptied in the same
// cycle; while a result waits to be taken, the input register can still take
// one more request and then holds it until the result is taken.
module line_follow_pd_drive_top (
  input  logic                        clk,
  input  logic                        rst_n,
  lfpd_in_if.sink                     in_ch,
  lfpd_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lfpd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [lfpd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  lfpd_pkg::cfg_t cfg;

  lfpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  logic              s1_valid_r;
  logic              s1_match_r;
  lfpd_pkg::sense_t  s1_bits_r;
  lfpd_pkg::speed_t  s1_speed_r;

  logic              out_valid_r;
  lfpd_pkg::drive_t  out_left_r;
  lfpd_pkg::drive_t  out_right_r;
  lfpd_pkg::perr_t   out_err_r;
  lfpd_pkg::perr_t   prev_err_r;

  logic              s2_ready;
  logic              s1_ready;
  logic              s1_fire;
  logic              load_out;
  logic              out_valid_nxt;
  lfpd_pkg::dec_t    dec;
  lfpd_pkg::perr_t   err;
  logic signed [4:0]  diff;
  logic [7:0]         kd;
  logic signed [12:0] p_term;
  logic signed [13:0] d_term;
  logic signed [14:0] u;
  logic signed [15:0] speed_s;
  logic signed [15:0] left_sum;
  logic signed [15:0] right_sum;

  assign s2_ready     = !out_valid_r || out_ch.ready;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_ch.ready  = s1_ready;
  assign s1_fire      = s1_valid_r && s2_ready;
  assign load_out     = s1_fire && s1_match_r;

  assign dec    = lfpd_pkg::decode_pattern(s1_bits_r);
  assign err    = dec.hit ? dec.err : prev_err_r;
  assign diff   = {err[3], err} - {prev_err_r[3], prev_err_r};
  assign kd     = (s1_speed_r >= cfg.speed_threshold) ? cfg.gain_rate_fast
                                                      : cfg.gain_rate_slow;
  assign p_term = $signed({1'b0, cfg.gain_error}) * err;
  assign d_term = $signed({1'b0, kd}) * diff;
  assign u      = 15'(p_term) + 15'(d_term);
  assign speed_s   = $signed({7'd0, s1_speed_r});
  assign left_sum  = speed_s + 16'(u);
  assign right_sum = speed_s - 16'(u);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_match_r <= (in_ch.echo_code == in_ch.line_color);
      s1_bits_r  <= in_ch.sensor_bits;
      s1_speed_r <= in_ch.top_speed;
    end
    if (load_out) begin
      out_left_r  <= lfpd_pkg::clamp_drive(left_sum, cfg.drive_limit);
      out_right_r <= lfpd_pkg::clamp_drive(right_sum, cfg.drive_limit);
      out_err_r   <= err;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_drive     = out_left_r;
  assign out_ch.right_drive    = out_right_r;
  assign out_ch.position_error = out_err_r;

`ifndef NO_ASSERTIONS
  // An empty result register must never hold back new requests.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while result register is empty");

  // A dropped request must leave the stored error alone.
  a_drop_keeps_err: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_match_r) |=> $stable(prev_err_r))
    else $error("color mismatch changed previous error");

  // A matching request always lands in the result register.
  a_match_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("matching request produced no result");

  // The reported error is the one carried forward to the next request.
  a_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_err_r == prev_err_r))
    else $error("reported error differs from stored error");

  // Position error stays within the decoded range.
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_err_r != -4'sd8))
    else $error("position error out of range");
`endif

endmodule

/* rtl/core/lfpd_cfg_regs.sv */
// APB-style configuration register file for the gains, threshold and limit.
module lfpd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0] paddr,
  input  logic [lfpd_pkg::DATA_W-1:0] pwdata,
  output logic [lfpd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lfpd_pkg::cfg_t              cfg
);

  lfpd_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[lfpd_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_error      <= lfpd_pkg::RST_GAIN_ERROR;
      cfg_r.gain_rate_fast  <= lfpd_pkg::RST_GAIN_RATE_FAST;
      cfg_r.gain_rate_slow  <= lfpd_pkg::RST_GAIN_RATE_SLOW;
      cfg_r.speed_threshold <= lfpd_pkg::RST_SPEED_THRESHOLD;
      cfg_r.drive_limit     <= lfpd_pkg::RST_DRIVE_LIMIT;
    end else if (wr_en) begin
      case (idx)
        lfpd_pkg::REG_GAIN_ERROR:      cfg_r.gain_error      <= pwdata[7:0];
        lfpd_pkg::REG_GAIN_RATE_FAST:  cfg_r.gain_rate_fast  <= pwdata[7:0];
        lfpd_pkg::REG_GAIN_RATE_SLOW:  cfg_r.gain_rate_slow  <= pwdata[7:0];
        lfpd_pkg::REG_SPEED_THRESHOLD: cfg_r.speed_threshold <= pwdata[8:0];
        lfpd_pkg::REG_DRIVE_LIMIT:     cfg_r.drive_limit     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lfpd_pkg::REG_GAIN_ERROR:      prdata = 32'(cfg_r.gain_error);
      lfpd_pkg::REG_GAIN_RATE_FAST:  prdata = 32'(cfg_r.gain_rate_fast);
      lfpd_pkg::REG_GAIN_RATE_SLOW:  prdata = 32'(cfg_r.gain_rate_slow);
      lfpd_pkg::REG_SPEED_THRESHOLD: prdata = 32'(cfg_r.speed_threshold);
      lfpd_pkg::REG_DRIVE_LIMIT:     prdata = 32'(cfg_r.drive_limit);
      default:                       prdata = '0;
    endcase
  end

endmodule
